// ----- hw/rtl/lpmt_pkg.sv -----
// shared types and constants for the longest prefix match trie
package lpmt_pkg;

    localparam int NODE_COUNT = 8192;
    localparam int ADDR_BITS  = 32;
    localparam int PORT_BITS  = 8;
    localparam int LEN_BITS   = 6;
    localparam int IDX_BITS   = $clog2(NODE_COUNT);
    localparam int FREE_BITS  = IDX_BITS + 1;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POOL_FULL = 2'd1,
        ST_BAD_LEN   = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    typedef struct packed {
        logic [IDX_BITS-1:0]  left;
        logic [IDX_BITS-1:0]  right;
        logic                 marked;
        logic [PORT_BITS-1:0] port;
    } t_node;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] idx;
        t_node               node;
    } t_wr_req;

endpackage

// ----- hw/rtl/lpmt_if.sv -----
// request and response channels of the prefix match trie
interface lpmt_req_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [lpmt_pkg::ADDR_BITS-1:0] address;
    logic [lpmt_pkg::LEN_BITS-1:0]  prefix_len;
    logic [lpmt_pkg::PORT_BITS-1:0] port;

    modport source (output valid, action, address, prefix_len, port, input ready);
    modport sink   (input valid, action, address, prefix_len, port, output ready);
endinterface

interface lpmt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [lpmt_pkg::PORT_BITS-1:0] found_port;
    logic                           hit;
    logic [1:0]                     status;

    modport source (output valid, found_port, hit, status, input ready);
    modport sink   (input valid, found_port, hit, status, output ready);
endinterface

// ----- hw/rtl/longest_prefix_match_trie.sv -----
// ipv4 longest prefix match on a one-bit binary trie held in a node ram
// a request is taken while idle, then walks one trie level per cycle off the ram
// read port: the result is valid in the cycle after the last walk step, and the
// next request is taken right after the walk
// a stalled response holds the walk on its last step until the result slot frees
// synchronous active-low reset empties the trie (root cleared, allocator at 1)
module longest_prefix_match_trie (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpmt_req_if.sink    i_req,
    lpmt_rsp_if.source  o_rsp
);

    localparam int IDXB = lpmt_pkg::IDX_BITS;
    localparam int LENB = lpmt_pkg::LEN_BITS;

    lpmt_pkg::t_state                  r_state, n_state;
    logic                              r_action, n_action;
    logic [lpmt_pkg::ADDR_BITS-1:0]    r_addr, n_addr;
    logic [LENB-1:0]                   r_len, n_len;
    logic [lpmt_pkg::PORT_BITS-1:0]    r_port, n_port;
    logic [LENB-1:0]                   r_depth, n_depth;
    lpmt_pkg::t_node                   r_cur, n_cur;
    logic [IDXB-1:0]                   r_idx, n_idx;
    logic                              r_use_rd, n_use_rd;
    logic [lpmt_pkg::FREE_BITS-1:0]    r_next_free, n_next_free;
    logic [lpmt_pkg::PORT_BITS-1:0]    r_found, n_found;
    logic                              r_hit, n_hit;
    logic                              r_out_valid, n_out_valid;
    logic [lpmt_pkg::PORT_BITS-1:0]    r_out_port, n_out_port;
    logic                              r_out_hit, n_out_hit;
    lpmt_pkg::t_status                 r_out_status, n_out_status;

    lpmt_pkg::t_wr_req                 w_wr;
    logic                              w_rd_en;
    logic [IDXB-1:0]                   w_rd_idx;
    lpmt_pkg::t_node                   w_rd_node;
    lpmt_pkg::t_node                   w_cur;
    lpmt_pkg::t_node                   w_upd;
    logic                              w_dir;
    logic [IDXB-1:0]                   w_child;
    logic                              w_out_free;
    logic                              w_done;
    logic [lpmt_pkg::PORT_BITS-1:0]    w_res_port;
    logic                              w_res_hit;
    lpmt_pkg::t_status                 w_res_status;

    lpmt_node_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_idx  (w_rd_idx),
        .o_rd_node (w_rd_node)
    );

    assign i_req.ready      = (r_state == lpmt_pkg::S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found_port = r_out_port;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.status     = r_out_status;

    // the node just read from ram takes the place of the held copy
    assign w_cur      = r_use_rd ? w_rd_node : r_cur;
    assign w_dir      = r_addr[lpmt_pkg::ADDR_BITS-1];
    assign w_child    = w_dir ? w_cur.right : w_cur.left;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpmt_pkg::S_IDLE;
            r_next_free <= lpmt_pkg::FREE_BITS'(1);
            r_out_valid <= 1'b0;
            r_use_rd    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
            r_use_rd    <= n_use_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_port       <= n_port;
        r_depth      <= n_depth;
        r_cur        <= n_cur;
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_hit        <= n_hit;
        r_out_port   <= n_out_port;
        r_out_hit    <= n_out_hit;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_addr       = r_addr;
        n_len        = r_len;
        n_port       = r_port;
        n_depth      = r_depth;
        n_cur        = w_cur;
        n_idx        = r_idx;
        n_use_rd     = 1'b0;
        n_next_free  = r_next_free;
        n_found      = r_found;
        n_hit        = r_hit;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_port   = r_out_port;
        n_out_hit    = r_out_hit;
        n_out_status = r_out_status;
        w_wr         = '0;
        w_rd_en      = 1'b0;
        w_rd_idx     = '0;
        w_upd        = w_cur;
        w_done       = 1'b0;
        w_res_port   = '0;
        w_res_hit    = 1'b0;
        w_res_status = lpmt_pkg::ST_OK;

        unique case (r_state)
            lpmt_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_action = i_req.action;
                    n_addr   = i_req.address;
                    n_len    = i_req.prefix_len;
                    n_port   = i_req.port;
                    n_depth  = '0;
                    n_idx    = '0;
                    n_found  = '0;
                    n_hit    = 1'b0;
                    // fetch the root
                    w_rd_en  = 1'b1;
                    w_rd_idx = '0;
                    n_use_rd = 1'b1;
                    n_state  = lpmt_pkg::S_WALK;
                end
            end
            lpmt_pkg::S_WALK: begin
                if (r_action == lpmt_pkg::ACT_INSERT) begin
                    if (r_len == '0 || r_len > LENB'(lpmt_pkg::ADDR_BITS)) begin
                        w_done       = 1'b1;
                        w_res_status = lpmt_pkg::ST_BAD_LEN;
                    end else if (r_depth == r_len) begin
                        w_upd.marked = 1'b1;
                        w_upd.port   = r_port;
                        w_wr.en      = 1'b1;
                        w_done       = 1'b1;
                    end else if (w_child != '0) begin
                        w_rd_en  = 1'b1;
                        w_rd_idx = w_child;
                        n_use_rd = 1'b1;
                        n_idx    = w_child;
                        n_depth  = r_depth + 1'b1;
                        n_addr   = r_addr << 1;
                    end else if (r_next_free == lpmt_pkg::FREE_BITS'(lpmt_pkg::NODE_COUNT)) begin
                        // write back so a freshly allocated node is left cleared
                        w_wr.en      = 1'b1;
                        w_done       = 1'b1;
                        w_res_status = lpmt_pkg::ST_POOL_FULL;
                    end else begin
                        if (w_dir) begin
                            w_upd.right = r_next_free[IDXB-1:0];
                        end else begin
                            w_upd.left = r_next_free[IDXB-1:0];
                        end
                        w_wr.en     = 1'b1;
                        n_cur       = '0;
                        n_idx       = r_next_free[IDXB-1:0];
                        n_next_free = r_next_free + 1'b1;
                        n_depth     = r_depth + 1'b1;
                        n_addr      = r_addr << 1;
                    end
                end else begin
                    if (w_cur.marked) begin
                        n_found = w_cur.port;
                        n_hit   = 1'b1;
                    end
                    if (r_depth == LENB'(lpmt_pkg::ADDR_BITS) || w_child == '0) begin
                        w_done     = 1'b1;
                        w_res_port = n_found;
                        w_res_hit  = n_hit;
                    end else begin
                        w_rd_en  = 1'b1;
                        w_rd_idx = w_child;
                        n_use_rd = 1'b1;
                        n_idx    = w_child;
                        n_depth  = r_depth + 1'b1;
                        n_addr   = r_addr << 1;
                    end
                end
                w_wr.idx  = r_idx;
                w_wr.node = w_upd;
                if (w_done) begin
                    if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_port   = w_res_port;
                        n_out_hit    = w_res_hit;
                        n_out_status = w_res_status;
                        n_state      = lpmt_pkg::S_IDLE;
                    end else begin
                        // result slot busy: hold this step and retry
                        w_wr.en = 1'b0;
                        n_found = r_found;
                        n_hit   = r_hit;
                        n_cur   = w_cur;
                    end
                end
            end
            default: begin
                n_state = lpmt_pkg::S_IDLE;
            end
        endcase
    end

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free != '0 &&
        r_next_free <= lpmt_pkg::FREE_BITS'(lpmt_pkg::NODE_COUNT))
        else $error("node allocator out of range");

    a_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> r_state == lpmt_pkg::S_WALK)
        else $error("node write outside a walk");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.hit |-> o_rsp.found_port == '0)
        else $error("miss with nonzero port");

    a_insert_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status != lpmt_pkg::ST_OK |-> !o_rsp.hit)
        else $error("error result flagged as hit");

    a_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_state == lpmt_pkg::S_WALK && r_use_rd)
        else $error("request taken without a root fetch");

endmodule

// ----- hw/rtl/lpmt_node_store.sv -----
// trie node store: node ram plus the root's child links held in flops
module lpmt_node_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lpmt_pkg::t_wr_req                 i_wr,
    input  logic                              i_rd_en,
    input  logic [lpmt_pkg::IDX_BITS-1:0]     i_rd_idx,
    output lpmt_pkg::t_node                   o_rd_node
);

    lpmt_pkg::t_node                  mem [lpmt_pkg::NODE_COUNT];
    lpmt_pkg::t_node                  r_rd_mem;
    logic                             r_rd_root;
    logic [lpmt_pkg::IDX_BITS-1:0]    r_root_left;
    logic [lpmt_pkg::IDX_BITS-1:0]    r_root_right;
    lpmt_pkg::t_node                  w_root;

    // root is cleared at reset; every other node is written when allocated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_left  <= '0;
            r_root_right <= '0;
        end else if (i_wr.en && i_wr.idx == '0) begin
            r_root_left  <= i_wr.node.left;
            r_root_right <= i_wr.node.right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.idx != '0) begin
            mem[i_wr.idx] <= i_wr.node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_mem  <= mem[i_rd_idx];
            r_rd_root <= (i_rd_idx == '0);
        end
    end

    always_comb begin
        w_root        = '0;
        w_root.left   = r_root_left;
        w_root.right  = r_root_right;
        o_rd_node     = r_rd_root ? w_root : r_rd_mem;
    end

endmodule

// ----- tb/sv/tb_longest_prefix_match_trie.sv -----
// self-checking testbench for the trie prefix match: directed table, random requests, model trie
module tb_longest_prefix_match_trie;

    typedef struct packed {
        logic                           action;
        logic [lpmt_pkg::ADDR_BITS-1:0] address;
        logic [lpmt_pkg::LEN_BITS-1:0]  prefix_len;
        logic [lpmt_pkg::PORT_BITS-1:0] port;
    } t_req_item;

    typedef struct packed {
        logic [lpmt_pkg::PORT_BITS-1:0] found_port;
        logic                           hit;
        lpmt_pkg::t_status              status;
    } t_answer;

    typedef struct packed {
        t_req_item req;
        logic      has_answer;
        t_answer   answer;
    } t_dir_row;

    typedef struct packed {
        logic [lpmt_pkg::ADDR_BITS-1:0] address;
        logic [lpmt_pkg::LEN_BITS-1:0]  prefix_len;
    } t_route;

    localparam int N_DIRECTED = 24;
    localparam int LONG_HOLD  = 600;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lpmt_req_if req_ch ();
    lpmt_rsp_if rsp_ch ();

    longest_prefix_match_trie i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model trie
    logic [lpmt_pkg::IDX_BITS-1:0]  trie_left   [lpmt_pkg::NODE_COUNT];
    logic [lpmt_pkg::IDX_BITS-1:0]  trie_right  [lpmt_pkg::NODE_COUNT];
    logic                           trie_marked [lpmt_pkg::NODE_COUNT];
    logic [lpmt_pkg::PORT_BITS-1:0] trie_port   [lpmt_pkg::NODE_COUNT];
    int unsigned                    trie_next_free;

    t_answer     pending_answers [$];
    t_route      routes_held [$];
    logic [11:0] route_bases [8];
    int          mismatch_count  = 0;
    int          requests_taken  = 0;
    int          pool_full_seen  = 0;
    int          burst_left      = 0;

    // top rows with the expected answer typed in; the others go through the model trie
    t_dir_row directed_rows [N_DIRECTED] = '{
        '{'{lpmt_pkg::ACT_LOOKUP, 32'h0000_0000, 6'd0,  8'h00}, 1'b1,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF}, 1'b1,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_INSERT, 32'hC0A8_0000, 6'd0,  8'h12}, 1'b1,
          '{8'h00, 1'b0, lpmt_pkg::ST_BAD_LEN}},
        '{'{lpmt_pkg::ACT_INSERT, 32'hC0A8_0000, 6'd33, 8'h34}, 1'b1,
          '{8'h00, 1'b0, lpmt_pkg::ST_BAD_LEN}},
        '{'{lpmt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 6'd63, 8'hFF}, 1'b1,
          '{8'h00, 1'b0, lpmt_pkg::ST_BAD_LEN}},
        '{'{lpmt_pkg::ACT_LOOKUP, 32'hC0A8_0001, 6'd0,  8'h00}, 1'b1,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_INSERT, 32'h8000_0000, 6'd1,  8'h11}, 1'b1,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_INSERT, 32'h0000_0000, 6'd1,  8'h22}, 1'b1,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF}, 1'b1,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_INSERT, 32'h0000_0000, 6'd32, 8'h00}, 1'b1,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0,  8'h00}, 1'b1,
          '{8'hFF, 1'b1, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_LOOKUP, 32'h0000_0000, 6'd0,  8'h00}, 1'b1,
          '{8'h00, 1'b1, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 6'd0,  8'h00}, 1'b0,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_LOOKUP, 32'hFFFF_FFFE, 6'd32, 8'hAA}, 1'b0,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_INSERT, 32'hC0A8_0000, 6'd16, 8'h5A}, 1'b0,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_LOOKUP, 32'hC0A8_1234, 6'd0,  8'h00}, 1'b0,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_INSERT, 32'hC0A8_0100, 6'd24, 8'hA5}, 1'b0,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_LOOKUP, 32'hC0A8_01FF, 6'd0,  8'h00}, 1'b0,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_LOOKUP, 32'hC0A9_0000, 6'd0,  8'h00}, 1'b0,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_INSERT, 32'hC0A8_FFFF, 6'd16, 8'h3C}, 1'b0,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_LOOKUP, 32'hC0A8_7777, 6'd0,  8'h00}, 1'b0,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_INSERT, 32'hAAAA_AAAA, 6'd31, 8'h96}, 1'b0,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_LOOKUP, 32'hAAAA_AAAB, 6'd0,  8'h00}, 1'b0,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}},
        '{'{lpmt_pkg::ACT_LOOKUP, 32'hAAAA_AAA8, 6'd0,  8'h00}, 1'b0,
          '{8'h00, 1'b0, lpmt_pkg::ST_OK}}
    };

    function automatic logic [lpmt_pkg::ADDR_BITS-1:0] prefix_mask(int len);
        if (len == 0) begin
            return '0;
        end
        return {lpmt_pkg::ADDR_BITS{1'b1}} << (lpmt_pkg::ADDR_BITS - len);
    endfunction

    function automatic t_answer predict_answer(t_req_item r);
        t_answer                       a;
        logic [lpmt_pkg::IDX_BITS-1:0] node;
        logic [lpmt_pkg::IDX_BITS-1:0] nxt;
        logic                          dir;
        a = '{found_port: '0, hit: 1'b0, status: lpmt_pkg::ST_OK};
        node = '0;
        if (r.action == lpmt_pkg::ACT_INSERT) begin
            if (r.prefix_len == '0 || int'(r.prefix_len) > lpmt_pkg::ADDR_BITS) begin
                a.status = lpmt_pkg::ST_BAD_LEN;
                return a;
            end
            for (int d = 0; d < int'(r.prefix_len); d++) begin
                dir = r.address[lpmt_pkg::ADDR_BITS-1-d];
                nxt = dir ? trie_right[node] : trie_left[node];
                if (nxt == '0) begin
                    // nodes taken so far by this request stay allocated
                    if (trie_next_free >= lpmt_pkg::NODE_COUNT) begin
                        a.status = lpmt_pkg::ST_POOL_FULL;
                        return a;
                    end
                    nxt = lpmt_pkg::IDX_BITS'(trie_next_free);
                    trie_next_free++;
                    trie_left[nxt]   = '0;
                    trie_right[nxt]  = '0;
                    trie_marked[nxt] = 1'b0;
                    trie_port[nxt]   = '0;
                    if (dir) begin
                        trie_right[node] = nxt;
                    end else begin
                        trie_left[node] = nxt;
                    end
                end
                node = nxt;
            end
            trie_marked[node] = 1'b1;
            trie_port[node]   = r.port;
        end else begin
            for (int d = 0; d <= lpmt_pkg::ADDR_BITS; d++) begin
                if (trie_marked[node]) begin
                    a.found_port = trie_port[node];
                    a.hit        = 1'b1;
                end
                if (d == lpmt_pkg::ADDR_BITS) begin
                    break;
                end
                node = r.address[lpmt_pkg::ADDR_BITS-1-d] ? trie_right[node]
                                                           : trie_left[node];
                if (node == '0) begin
                    break;
                end
            end
        end
        return a;
    endfunction

    function automatic t_req_item random_lookup();
        t_req_item                      r;
        t_route                         p;
        logic [lpmt_pkg::ADDR_BITS-1:0] m;
        int                             flip;
        r.action     = lpmt_pkg::ACT_LOOKUP;
        r.address    = lpmt_pkg::ADDR_BITS'($urandom);
        r.prefix_len = lpmt_pkg::LEN_BITS'($urandom);
        r.port       = lpmt_pkg::PORT_BITS'($urandom);
        if (routes_held.size() != 0 && $urandom_range(0, 9) < 7) begin
            p = routes_held[$urandom_range(0, routes_held.size() - 1)];
            m = prefix_mask(int'(p.prefix_len));
            r.address = (p.address & m) | (r.address & ~m);
            // step off the route at its last bit
            if ($urandom_range(0, 4) == 0) begin
                flip = lpmt_pkg::ADDR_BITS - int'(p.prefix_len);
                r.address[flip] = ~r.address[flip];
            end
        end
        return r;
    endfunction

    function automatic t_req_item random_insert(bit full_length);
        t_req_item r;
        t_route    p;
        int        pick;
        r.action  = lpmt_pkg::ACT_INSERT;
        r.address = lpmt_pkg::ADDR_BITS'($urandom);
        r.port    = lpmt_pkg::PORT_BITS'($urandom);
        pick      = int'($urandom_range(0, 99));
        if (full_length) begin
            r.prefix_len = lpmt_pkg::LEN_BITS'(lpmt_pkg::ADDR_BITS);
        end else if (pick < 55) begin
            r.prefix_len = lpmt_pkg::LEN_BITS'($urandom_range(1, 20));
            if ($urandom_range(0, 1) == 1) begin
                r.address[lpmt_pkg::ADDR_BITS-1 -: 12] = route_bases[3'($urandom_range(0, 7))];
            end
        end else if (pick < 80) begin
            r.prefix_len = lpmt_pkg::LEN_BITS'($urandom_range(21, lpmt_pkg::ADDR_BITS));
            r.address[lpmt_pkg::ADDR_BITS-1 -: 12] = route_bases[3'($urandom_range(0, 7))];
        end else if (pick < 94 && routes_held.size() != 0) begin
            // same route again, new port, junk below the prefix
            p = routes_held[$urandom_range(0, routes_held.size() - 1)];
            r.address    = (p.address & prefix_mask(int'(p.prefix_len)))
                           | (r.address & ~prefix_mask(int'(p.prefix_len)));
            r.prefix_len = p.prefix_len;
        end else if ($urandom_range(0, 2) == 0) begin
            r.prefix_len = '0;
        end else begin
            r.prefix_len = lpmt_pkg::LEN_BITS'($urandom_range(lpmt_pkg::ADDR_BITS + 1, 63));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    task automatic offer_request(t_req_item r, bit has_answer, t_answer answer);
        t_answer a;
        int      gap;
        req_ch.valid      <= 1'b1;
        req_ch.action     <= r.action;
        req_ch.address    <= r.address;
        req_ch.prefix_len <= r.prefix_len;
        req_ch.port       <= r.port;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        a = predict_answer(r);
        pending_answers.push_back(has_answer ? answer : a);
        requests_taken++;
        if (a.status == lpmt_pkg::ST_POOL_FULL) begin
            pool_full_seen++;
        end
        if (r.action == lpmt_pkg::ACT_INSERT && a.status == lpmt_pkg::ST_OK &&
            routes_held.size() < 4096) begin
            routes_held.push_back('{r.address, r.prefix_len});
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 40));
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? int'($urandom_range(20, 40))
                                                      : int'($urandom_range(0, 6));
        end
    endtask

    initial begin
        req_ch.valid      <= 1'b0;
        req_ch.action     <= lpmt_pkg::ACT_LOOKUP;
        req_ch.address    <= '0;
        req_ch.prefix_len <= '0;
        req_ch.port       <= '0;
        i_rst_n           <= 1'b0;
        for (int n = 0; n < lpmt_pkg::NODE_COUNT; n++) begin
            trie_left[lpmt_pkg::IDX_BITS'(n)]   = '0;
            trie_right[lpmt_pkg::IDX_BITS'(n)]  = '0;
            trie_marked[lpmt_pkg::IDX_BITS'(n)] = 1'b0;
            trie_port[lpmt_pkg::IDX_BITS'(n)]   = '0;
        end
        trie_next_free = 1;
        for (int b = 0; b < 8; b++) begin
            route_bases[3'(b)] = 12'($urandom);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            offer_request(directed_rows[k].req, directed_rows[k].has_answer,
                          directed_rows[k].answer);
        end

        repeat (1500) begin
            offer_request(($urandom_range(0, 1) == 1) ? random_insert(1'b0) : random_lookup(),
                          1'b0, '0);
        end
        // long random routes until the node pool runs dry
        while (pool_full_seen < 6) begin
            offer_request(($urandom_range(0, 9) < 6) ? random_insert(1'b1) : random_lookup(),
                          1'b0, '0);
        end
        repeat (150) begin
            offer_request(($urandom_range(0, 1) == 1) ? random_insert(1'b0) : random_lookup(),
                          1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (pending_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // receiver stall pattern, with one long hold-off to back up the request side
    initial begin
        bit held_off;
        held_off = 1'b0;
        rsp_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) begin
            @(posedge i_clk);
        end
        forever begin
            if (!held_off && requests_taken >= 200) begin
                held_off = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            case ($urandom_range(0, 3))
                0: begin
                    rsp_ch.ready <= 1'b1;
                    repeat ($urandom_range(20, 200)) @(posedge i_clk);
                end
                1: begin
                    rsp_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge i_clk);
                end
                default: begin
                    repeat ($urandom_range(4, 60)) begin
                        rsp_ch.ready <= 1'($urandom_range(0, 1));
                        @(posedge i_clk);
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("response with no request pending", 32'h1, 32'h0);
            end else begin
                want = pending_answers.pop_front();
                if (rsp_ch.found_port !== want.found_port) begin
                    report_mismatch("found_port", 32'(rsp_ch.found_port),
                                    32'(want.found_port));
                end
                if (rsp_ch.hit !== want.hit) begin
                    report_mismatch("hit", 32'(rsp_ch.hit), 32'(want.hit));
                end
                if (rsp_ch.status !== want.status) begin
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lpmt_pkg.sv
hw/rtl/lpmt_if.sv
hw/rtl/lpmt_node_store.sv
hw/rtl/longest_prefix_match_trie.sv
tb/sv/tb_longest_prefix_match_trie.sv
